/* hw/rtl/spm_pkg.sv */
// spm_pkg: shared types and constants for the spectral poisson mode solver
// used by the top level, the pipelined divider and the port checker
`timescale 1ns / 1ps

package spm_pkg;

    localparam int LANES   = 6;
    localparam int Q_W     = 33;
    localparam int DEN_W   = 81;
    localparam int REM_W   = 113;
    localparam int DIV_STEPS = Q_W;
    // four front stages, the divider, one output stage
    localparam int LATENCY = 4 + DIV_STEPS + 1;

    typedef logic [REM_W-1:0] rem_t;
    typedef logic [Q_W-1:0]   quo_t;
    typedef logic [DEN_W-1:0] den_t;

    typedef enum logic [1:0] {
        CFG_KX_STEP = 2'd0,
        CFG_KY_STEP = 2'd1,
        CFG_NORM    = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [LANES-1:0] neg;
        logic             zero;
    } div_tag_t;

endpackage

/* hw/rtl/spectral_poisson_mode_solver_top.sv */
// spectral_poisson_mode_solver_top: per-mode poisson solve, phi and e field
// depends on spm_pkg and spm_divider
`timescale 1ns / 1ps
//
// channel   | signals                                   | transaction when
// ----------+-------------------------------------------+------------------------
// mode in   | start, busy, mode_col/row, rho_re/im      | start high, busy low
// result    | done, phi_*, ex_*, ey_*, saturated        | done high (one cycle)
// config    | cfg_we, cfg_addr, cfg_wdata               | cfg_we high
//
// one mode per cycle; the 33-step restoring divider
// (one quotient bit per stage, six lanes) sets the depth
// busy stays low, every stage moves each cycle, nothing stalls
// reset clears the valid bits and loads the register reset values

module spectral_poisson_mode_solver_top
    import spm_pkg::*;
#(
    parameter int NX_HALF = 129,
    parameter int NY      = 256
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [7:0]         mode_col,
    input  logic [7:0]         mode_row,
    input  logic signed [31:0] rho_re,
    input  logic signed [31:0] rho_im,
    output logic               done,
    output logic signed [31:0] phi_re,
    output logic signed [31:0] phi_im,
    output logic signed [31:0] ex_re,
    output logic signed [31:0] ex_im,
    output logic signed [31:0] ey_re,
    output logic signed [31:0] ey_im,
    output logic               saturated,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_addr,
    input  logic [31:0]        cfg_wdata
);

    logic [31:0] kx_step_reg, ky_step_reg, norm_reg;
    logic [63:0] sx2_reg, sy2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kx_step_reg <= 32'h0100_0000;
            ky_step_reg <= 32'h0100_0000;
            norm_reg    <= 32'h0001_0000;
            sx2_reg     <= 64'h0001_0000_0000_0000;
            sy2_reg     <= 64'h0001_0000_0000_0000;
        end
        else
        begin
            sx2_reg <= 64'(kx_step_reg) * 64'(kx_step_reg);
            sy2_reg <= 64'(ky_step_reg) * 64'(ky_step_reg);
            if (cfg_we)
            begin
                unique case (cfg_idx_t'(cfg_addr))
                    CFG_KX_STEP: kx_step_reg <= cfg_wdata;
                    CFG_KY_STEP: ky_step_reg <= cfg_wdata;
                    CFG_NORM:    norm_reg    <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    assign busy = 1'b0;

    // stage a: magnitudes, signed row, wavenumbers
    logic        vld_a_reg;
    logic [31:0] mre_a_reg, mim_a_reg;
    logic        nre_a_reg, nim_a_reg, rneg_a_reg, oor_a_reg;
    logic [39:0] kx_a_reg, ky_a_reg;
    logic [15:0] c2_a_reg, r2_a_reg;

    logic [31:0] rre_u, rim_u, mre_next, mim_next;
    logic [7:0]  rmag_next;
    logic        rneg_next, oor_next;

    always_comb
    begin
        rre_u    = rho_re;
        rim_u    = rho_im;
        mre_next = rre_u[31] ? (~rre_u + 32'd1) : rre_u;
        mim_next = rim_u[31] ? (~rim_u + 32'd1) : rim_u;
        oor_next = (int'(mode_col) >= NX_HALF) || (int'(mode_row) >= NY);
        if (int'(mode_row) > NY / 2)
        begin
            rmag_next = 8'(NY - int'(mode_row));
            rneg_next = 1'b1;
        end
        else
        begin
            rmag_next = mode_row;
            rneg_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_a_reg <= 1'b0;
        else
            vld_a_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        mre_a_reg  <= mre_next;
        mim_a_reg  <= mim_next;
        nre_a_reg  <= rre_u[31];
        nim_a_reg  <= rim_u[31];
        rneg_a_reg <= rneg_next;
        oor_a_reg  <= oor_next;
        kx_a_reg   <= 40'(mode_col) * 40'(kx_step_reg);
        ky_a_reg   <= 40'(rmag_next) * 40'(ky_step_reg);
        c2_a_reg   <= 16'(mode_col) * 16'(mode_col);
        r2_a_reg   <= 16'(rmag_next) * 16'(rmag_next);
    end

    // stage b: rho*norm, partial squares
    logic        vld_b_reg;
    logic [63:0] rn_re_b_reg, rn_im_b_reg;
    logic [47:0] kx2_lo_b_reg, kx2_hi_b_reg, ky2_lo_b_reg, ky2_hi_b_reg;
    logic [39:0] kx_b_reg, ky_b_reg;
    logic        nre_b_reg, nim_b_reg, rneg_b_reg, oor_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_b_reg <= 1'b0;
        else
            vld_b_reg <= vld_a_reg;
    end

    always_ff @(posedge clk)
    begin
        rn_re_b_reg  <= 64'(mre_a_reg) * 64'(norm_reg);
        rn_im_b_reg  <= 64'(mim_a_reg) * 64'(norm_reg);
        kx2_lo_b_reg <= 48'(c2_a_reg) * 48'(sx2_reg[31:0]);
        kx2_hi_b_reg <= 48'(c2_a_reg) * 48'(sx2_reg[63:32]);
        ky2_lo_b_reg <= 48'(r2_a_reg) * 48'(sy2_reg[31:0]);
        ky2_hi_b_reg <= 48'(r2_a_reg) * 48'(sy2_reg[63:32]);
        kx_b_reg     <= kx_a_reg;
        ky_b_reg     <= ky_a_reg;
        nre_b_reg    <= nre_a_reg;
        nim_b_reg    <= nim_a_reg;
        rneg_b_reg   <= rneg_a_reg;
        oor_b_reg    <= oor_a_reg;
    end

    // stage c: squares summed, numerator partial products
    // products: 0 rn_im*kx, 1 rn_re*kx, 2 rn_im*ky, 3 rn_re*ky
    logic        vld_c_reg;
    den_t        kx2_c_reg, ky2_c_reg;
    logic [63:0] rn_re_c_reg, rn_im_c_reg;
    logic [63:0] p0_c_reg [4];
    logic [63:0] p1_c_reg [4];
    logic [71:0] p2_c_reg [4];
    logic        nre_c_reg, nim_c_reg, rneg_c_reg, oor_c_reg;

    logic [63:0] rn_sel [4];
    logic [39:0] k_sel  [4];

    always_comb
    begin
        rn_sel[0] = rn_im_b_reg;
        rn_sel[1] = rn_re_b_reg;
        rn_sel[2] = rn_im_b_reg;
        rn_sel[3] = rn_re_b_reg;
        k_sel[0]  = kx_b_reg;
        k_sel[1]  = kx_b_reg;
        k_sel[2]  = ky_b_reg;
        k_sel[3]  = ky_b_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_c_reg <= 1'b0;
        else
            vld_c_reg <= vld_b_reg;
    end

    always_ff @(posedge clk)
    begin
        kx2_c_reg   <= DEN_W'(kx2_lo_b_reg) + (DEN_W'(kx2_hi_b_reg) << 32);
        ky2_c_reg   <= DEN_W'(ky2_lo_b_reg) + (DEN_W'(ky2_hi_b_reg) << 32);
        rn_re_c_reg <= rn_re_b_reg;
        rn_im_c_reg <= rn_im_b_reg;
        for (int j = 0; j < 4; j++)
        begin
            p0_c_reg[j] <= 64'(rn_sel[j][31:0]) * 64'(k_sel[j][31:0]);
            p1_c_reg[j] <= 64'(rn_sel[j][63:32]) * 64'(k_sel[j][31:0]);
            p2_c_reg[j] <= 72'(rn_sel[j]) * 72'(k_sel[j][39:32]);
        end
        nre_c_reg  <= nre_b_reg;
        nim_c_reg  <= nim_b_reg;
        rneg_c_reg <= rneg_b_reg;
        oor_c_reg  <= oor_b_reg;
    end

    // stage d: numerators, denominator, lane signs
    logic     vld_d_reg;
    rem_t     num_d_reg [LANES];
    den_t     den_d_reg;
    div_tag_t tag_d_reg;

    rem_t     num_next [LANES];
    div_tag_t tag_next;

    always_comb
    begin
        num_next[0] = rem_t'(rn_re_c_reg) << 16;
        num_next[1] = rem_t'(rn_im_c_reg) << 16;
        for (int j = 0; j < 4; j++)
            num_next[2+j] = (rem_t'(p0_c_reg[j]) + (rem_t'(p1_c_reg[j]) << 32)
                             + (rem_t'(p2_c_reg[j]) << 32)) << 8;
        // -i*(a+ib) = b - i*a
        tag_next.neg[0] = nre_c_reg;
        tag_next.neg[1] = nim_c_reg;
        tag_next.neg[2] = nim_c_reg;
        tag_next.neg[3] = !nre_c_reg;
        tag_next.neg[4] = nim_c_reg ^ rneg_c_reg;
        tag_next.neg[5] = !nre_c_reg ^ rneg_c_reg;
        tag_next.zero   = oor_c_reg || (kx2_c_reg == '0 && ky2_c_reg == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_d_reg <= 1'b0;
        else
            vld_d_reg <= vld_c_reg;
    end

    always_ff @(posedge clk)
    begin
        num_d_reg <= num_next;
        den_d_reg <= kx2_c_reg + ky2_c_reg;
        tag_d_reg <= tag_next;
    end

    logic     div_vld;
    quo_t     div_quo [LANES];
    div_tag_t div_tag;

    spm_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vld_d_reg),
        .num       (num_d_reg),
        .den       (den_d_reg),
        .in_tag    (tag_d_reg),
        .out_valid (div_vld),
        .quo       (div_quo),
        .out_tag   (div_tag)
    );

    // output stage: clip, apply sign, zero the mean mode and out-of-range modes
    logic        done_reg;
    logic [31:0] res_reg [LANES];
    logic        sat_reg;

    logic [31:0] res_next [LANES];
    logic        sat_next;
    quo_t        lim;
    logic [31:0] mag;

    always_comb
    begin
        sat_next = 1'b0;
        lim      = '0;
        mag      = '0;
        for (int l = 0; l < LANES; l++)
        begin
            lim = div_tag.neg[l] ? Q_W'(33'h0_8000_0000) : Q_W'(33'h0_7FFF_FFFF);
            if (div_quo[l] > lim)
            begin
                mag      = lim[31:0];
                sat_next = sat_next | !div_tag.zero;
            end
            else
                mag = div_quo[l][31:0];
            if (div_tag.zero)
                res_next[l] = '0;
            else if (div_tag.neg[l])
                res_next[l] = ~mag + 32'd1;
            else
                res_next[l] = mag;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= div_vld;
    end

    always_ff @(posedge clk)
    begin
        if (div_vld)
        begin
            res_reg <= res_next;
            sat_reg <= sat_next;
        end
    end

    assign done      = done_reg;
    assign phi_re    = res_reg[0];
    assign phi_im    = res_reg[1];
    assign ex_re     = res_reg[2];
    assign ex_im     = res_reg[3];
    assign ey_re     = res_reg[4];
    assign ey_im     = res_reg[5];
    assign saturated = sat_reg;

endmodule

/* hw/rtl/spm_divider.sv */
// spm_divider: six-lane restoring divider, one quotient bit per stage
// depends on spm_pkg
`timescale 1ns / 1ps

module spm_divider
    import spm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  rem_t     num [LANES],
    input  den_t     den,
    input  div_tag_t in_tag,
    output logic     out_valid,
    output quo_t     quo [LANES],
    output div_tag_t out_tag
);

    rem_t     rem_reg [DIV_STEPS][LANES];
    quo_t     quo_reg [DIV_STEPS][LANES];
    den_t     den_reg [DIV_STEPS];
    div_tag_t tag_reg [DIV_STEPS];
    logic [DIV_STEPS-1:0] vld_reg;

    for (genvar s = 0; s < DIV_STEPS; s++) begin : g_stage
        rem_t     rem_src  [LANES];
        quo_t     quo_src  [LANES];
        den_t     den_src;
        div_tag_t tag_src;
        logic     vld_src;
        rem_t     rem_next [LANES];
        quo_t     quo_next [LANES];
        rem_t     dsh;

        if (s == 0) begin : g_first
            always_comb
            begin
                for (int l = 0; l < LANES; l++)
                begin
                    rem_src[l] = num[l];
                    quo_src[l] = '0;
                end
                den_src = den;
                tag_src = in_tag;
                vld_src = in_valid;
            end
        end else begin : g_rest
            always_comb
            begin
                for (int l = 0; l < LANES; l++)
                begin
                    rem_src[l] = rem_reg[s-1][l];
                    quo_src[l] = quo_reg[s-1][l];
                end
                den_src = den_reg[s-1];
                tag_src = tag_reg[s-1];
                vld_src = vld_reg[s-1];
            end
        end

        // divisor aligned to quotient bit Q_W-1-s
        assign dsh = rem_t'(den_src) << (Q_W - 1 - s);

        always_comb
        begin
            for (int l = 0; l < LANES; l++)
            begin
                if (rem_src[l] >= dsh)
                begin
                    rem_next[l] = rem_src[l] - dsh;
                    quo_next[l] = {quo_src[l][Q_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next[l] = rem_src[l];
                    quo_next[l] = {quo_src[l][Q_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[s] <= 1'b0;
            else
                vld_reg[s] <= vld_src;
        end

        always_ff @(posedge clk)
        begin
            rem_reg[s] <= rem_next;
            quo_reg[s] <= quo_next;
            den_reg[s] <= den_src;
            tag_reg[s] <= tag_src;
        end
    end

    assign out_valid = vld_reg[DIV_STEPS-1];
    assign quo       = quo_reg[DIV_STEPS-1];
    assign out_tag   = tag_reg[DIV_STEPS-1];

endmodule

/* hw/rtl/spm_checker.sv */
// spm_checker: port-level checks for the spectral poisson mode solver
// depends on spm_pkg; bound to spectral_poisson_mode_solver_top
`timescale 1ns / 1ps

module spm_checker
    import spm_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic        saturated,
    input logic [31:0] phi_re,
    input logic [31:0] phi_im,
    input logic [31:0] ex_re,
    input logic [31:0] ex_im,
    input logic [31:0] ey_re,
    input logic [31:0] ey_im
);

    // every result comes from an earlier transaction
    a_done_from_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LATENCY))
        else $error("result without matching transaction");

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised");

    // a clipped result shows a rail value somewhere
    a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
        done && saturated |->
            phi_re == 32'h7FFF_FFFF || phi_re == 32'h8000_0000 ||
            phi_im == 32'h7FFF_FFFF || phi_im == 32'h8000_0000 ||
            ex_re  == 32'h7FFF_FFFF || ex_re  == 32'h8000_0000 ||
            ex_im  == 32'h7FFF_FFFF || ex_im  == 32'h8000_0000 ||
            ey_re  == 32'h7FFF_FFFF || ey_re  == 32'h8000_0000 ||
            ey_im  == 32'h7FFF_FFFF || ey_im  == 32'h8000_0000)
        else $error("saturated flag without a clipped value");

endmodule

bind spectral_poisson_mode_solver_top spm_checker u_spm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .done      (done),
    .saturated (saturated),
    .phi_re    (phi_re),
    .phi_im    (phi_im),
    .ex_re     (ex_re),
    .ex_im     (ex_im),
    .ey_re     (ey_re),
    .ey_im     (ey_im)
);
